### rtl/pp2hp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PROXY v2 header parser package
// Item types, status codes and constants shared by the parser files.
// ----------------------------------------------------------------------------
package pp2hp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  addr_family;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [15:0] src_port;
    } out_item_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_SIG     = 3'd1;
    localparam logic [2:0] ST_EOF_FIXED   = 3'd2;
    localparam logic [2:0] ST_BAD_CMD     = 3'd3;
    localparam logic [2:0] ST_EOF_HEADER  = 3'd4;
    localparam logic [2:0] ST_SHORT_V4    = 3'd5;
    localparam logic [2:0] ST_SHORT_V6    = 3'd6;
    localparam logic [2:0] ST_BAD_FAMILY  = 3'd7;

    localparam logic [1:0] AF_NONE = 2'd0;
    localparam logic [1:0] AF_TCP4 = 2'd1;
    localparam logic [1:0] AF_TCP6 = 2'd2;

    localparam logic [7:0] FAM_UNSPEC = 8'h00;
    localparam logic [7:0] FAM_TCP4   = 8'h11;
    localparam logic [7:0] FAM_TCP6   = 8'h21;
    localparam logic [7:0] CMD_LOCAL  = 8'h20;
    localparam logic [7:0] CMD_PROXY  = 8'h21;

    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] FIXED_LEN  = 17'd16;
    localparam logic [POS_W-1:0] POS_CMD    = 17'd12;
    localparam logic [POS_W-1:0] POS_FAM    = 17'd13;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd14;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd15;
    localparam logic [15:0] IPV4_ADDR_LEN = 16'd12;
    localparam logic [15:0] IPV6_ADDR_LEN = 16'd36;

    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h0D;
            4'd1:    b = 8'h0A;
            4'd2:    b = 8'h0D;
            4'd3:    b = 8'h0A;
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h0D;
            4'd6:    b = 8'h0A;
            4'd7:    b = 8'h51;
            4'd8:    b = 8'h55;
            4'd9:    b = 8'h49;
            4'd10:   b = 8'h54;
            4'd11:   b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/pp2hp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PROXY v2 header parser stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface pp2hp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface
`default_nettype wire

### rtl/pp2hp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PROXY v2 header parser state
// Holds the per-connection parse state and works out the result of one byte.
// ----------------------------------------------------------------------------
module pp2hp_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire pp2hp_pkg::in_item_t   item,
    output logic                       emit,
    output pp2hp_pkg::out_item_t       result
);
    import pp2hp_pkg::*;

    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [15:0]      hlen_reg,    hlen_next;
    logic             sig_good_reg, sig_good_next;
    logic [7:0]       cmd_reg,     cmd_next;
    logic [7:0]       fam_reg,     fam_next;
    logic [63:0]      addr_hi_reg, addr_hi_next;
    logic [63:0]      addr_lo_reg, addr_lo_next;
    logic [15:0]      port_reg,    port_next;
    logic             done_reg,    done_next;

    logic [POS_W-1:0] off;
    logic [POS_W-1:0] off_plus1;
    logic [7:0]       b;
    out_item_t        fin_res;
    out_item_t        err_res;
    logic [2:0]       err_status;
    logic             take_fin;
    logic             take_err;

    assign b         = item.data_byte;
    assign off       = pos_reg - FIXED_LEN;
    assign off_plus1 = off + 17'd1;

    always_comb
    begin
        pos_next      = pos_reg;
        hlen_next     = hlen_reg;
        sig_good_next = sig_good_reg;
        cmd_next      = cmd_reg;
        fam_next      = fam_reg;
        addr_hi_next  = addr_hi_reg;
        addr_lo_next  = addr_lo_reg;
        port_next     = port_reg;
        done_next     = done_reg;
        take_fin      = 1'b0;
        take_err      = 1'b0;
        err_status    = ST_OK;
        if (step)
        begin
            if (item.end_of_stream)
            begin
                if (!done_reg)
                begin
                    take_err   = 1'b1;
                    err_status = (pos_reg < FIXED_LEN) ? ST_EOF_FIXED : ST_EOF_HEADER;
                end
                pos_next      = '0;
                hlen_next     = '0;
                sig_good_next = 1'b1;
                cmd_next      = '0;
                fam_next      = '0;
                addr_hi_next  = '0;
                addr_lo_next  = '0;
                port_next     = '0;
                done_next     = 1'b0;
            end
            else if (!done_reg)
            begin
                pos_next = pos_reg + 17'd1;
                priority if (pos_reg < POS_CMD)
                begin
                    if (b != sig_byte(pos_reg[3:0]))
                    begin
                        sig_good_next = 1'b0;
                    end
                end
                else if (pos_reg == POS_CMD)
                begin
                    cmd_next = b;
                end
                else if (pos_reg == POS_FAM)
                begin
                    fam_next = b;
                end
                else if (pos_reg == POS_LEN_HI)
                begin
                    hlen_next = {b, 8'h00};
                end
                else if (pos_reg == POS_LEN_LO)
                begin
                    hlen_next = {hlen_reg[15:8], b};
                    priority if (!sig_good_reg)
                    begin
                        take_err   = 1'b1;
                        err_status = ST_BAD_SIG;
                    end
                    else if (cmd_reg != CMD_LOCAL && cmd_reg != CMD_PROXY)
                    begin
                        take_err   = 1'b1;
                        err_status = ST_BAD_CMD;
                    end
                    else if (hlen_next == 16'd0)
                    begin
                        take_fin = 1'b1;
                    end
                    else
                    begin
                        take_fin = 1'b0;
                    end
                end
                else
                begin
                    if (fam_reg == FAM_TCP4)
                    begin
                        if (off < 17'd4)
                        begin
                            addr_lo_next = {32'h0, addr_lo_reg[23:0], b};
                        end
                        else if (off == 17'd8 || off == 17'd9)
                        begin
                            port_next = {port_reg[7:0], b};
                        end
                    end
                    else if (fam_reg == FAM_TCP6)
                    begin
                        if (off < 17'd8)
                        begin
                            addr_hi_next = {addr_hi_reg[55:0], b};
                        end
                        else if (off < 17'd16)
                        begin
                            addr_lo_next = {addr_lo_reg[55:0], b};
                        end
                        else if (off == 17'd32 || off == 17'd33)
                        begin
                            port_next = {port_reg[7:0], b};
                        end
                    end
                    if (off_plus1 >= {1'b0, hlen_reg})
                    begin
                        take_fin = 1'b1;
                    end
                end
                if (take_fin || take_err)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        fin_res = '0;
        priority if (fam_reg == FAM_UNSPEC)
        begin
            fin_res.status = ST_OK;
        end
        else if (fam_reg == FAM_TCP4)
        begin
            if (hlen_next < IPV4_ADDR_LEN)
            begin
                fin_res.status = ST_SHORT_V4;
            end
            else
            begin
                fin_res.status       = ST_OK;
                fin_res.addr_family  = AF_TCP4;
                fin_res.src_addr_low = {32'h0, addr_lo_next[31:0]};
                fin_res.src_port     = port_next;
            end
        end
        else if (fam_reg == FAM_TCP6)
        begin
            if (hlen_next < IPV6_ADDR_LEN)
            begin
                fin_res.status = ST_SHORT_V6;
            end
            else
            begin
                fin_res.status        = ST_OK;
                fin_res.addr_family   = AF_TCP6;
                fin_res.src_addr_high = addr_hi_next;
                fin_res.src_addr_low  = addr_lo_next;
                fin_res.src_port      = port_next;
            end
        end
        else
        begin
            fin_res.status = ST_BAD_FAMILY;
        end
    end

    always_comb
    begin
        err_res        = '0;
        err_res.status = err_status;
    end

    assign emit   = take_fin || take_err;
    assign result = take_err ? err_res : fin_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hlen_reg     <= '0;
            sig_good_reg <= 1'b1;
            cmd_reg      <= '0;
            fam_reg      <= '0;
            addr_hi_reg  <= '0;
            addr_lo_reg  <= '0;
            port_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            hlen_reg     <= hlen_next;
            sig_good_reg <= sig_good_next;
            cmd_reg      <= cmd_next;
            fam_reg      <= fam_next;
            addr_hi_reg  <= addr_hi_next;
            addr_lo_reg  <= addr_lo_next;
            port_reg     <= port_next;
            done_reg     <= done_next;
        end
    end

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.end_of_stream |=> pos_reg == '0 && !done_reg && sig_good_reg)
        else $error("End of stream did not return the parser to its start state.");

    a_result_marks_done: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.end_of_stream && emit |=> done_reg)
        else $error("A header result did not mark the connection finished.");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !(step && item.end_of_stream) |-> !emit)
        else $error("A second result was produced for one connection.");

    a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        emit && result.status != ST_OK |->
            result.addr_family == AF_NONE && result.src_port == 16'd0 &&
            result.src_addr_high == 64'd0 && result.src_addr_low == 64'd0)
        else $error("An error result carries address fields.");

endmodule
`default_nettype wire

### rtl/proxy_v2_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PROXY v2 header parser
// Parses a PROXY protocol v2 header from a byte stream and reports the
// source address and port, or an error status, once per connection.
//
//   Channel   Role    Payload
//   bytes     sink    data_byte[7:0], end_of_stream
//   results   source  status[2:0], addr_family[1:0], src_addr_high[63:0],
//                     src_addr_low[63:0], src_port[15:0]
//
// One byte transfer is taken in every cycle unless a held result stalls;
// its result, if any, is valid in the output register on the next cycle.
// The byte position compare and capture are combinational, between the parse
// state and the output register.
// Reset returns the parser to the start of a connection with no result held.
// A stalled result holds the output register and stops byte transfers only
// while it is not taken.
// ----------------------------------------------------------------------------
module proxy_v2_header_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pp2hp_stream_if.sink    bytes,
    pp2hp_stream_if.source  results
);
    import pp2hp_pkg::*;

    logic      accept;
    logic      emit;
    out_item_t result;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign bytes.ready = !out_valid_reg || results.ready;
    assign accept      = bytes.valid && bytes.ready;

    pp2hp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .item   (bytes.payload),
        .emit   (emit),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= emit;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |-> !accept)
        else $error("A byte transfer was taken over a result that is still held.");

    a_result_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit |=> out_valid_reg)
        else $error("A parser result did not reach the output register.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !emit |=> !out_valid_reg)
        else $error("The output register shows a result that was not produced.");

endmodule
`default_nettype wire
